@@ hw/rtl/gpr_pkg.sv @@
// gpr_pkg: shared types and constants for the graph path reachability core
// holds the item mode codes, the sequencer states and the fixed field widths
// no dependencies
package gpr_pkg;

  // fixed widths of the item fields
  localparam int NODE_W = 6;
  localparam int MODE_W = 2;

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_SCAN,
    S_PUSH,
    S_POP,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/gpr_edge_mem.sv @@
// gpr_edge_mem: adjacency matrix, one row of node bits per source node
// synchronous memory with a registered read port; per-row valid flags make
// unwritten rows read as empty after reset. depends on nothing
module gpr_edge_mem #(
  parameter int NODES = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [NODES-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [NODES-1:0] wr_data
);

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] mem_rd_r;
  logic [NODES-1:0] row_vld_r;
  logic             rd_vld_r;

  // row storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // row valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // a row never written reads as no edges
  assign rd_data = rd_vld_r ? mem_rd_r : '0;

endmodule

@@ hw/rtl/gpr_stack_mem.sv @@
// gpr_stack_mem: depth-first search stack of node indices
// synchronous memory with a registered read port, contents undefined until
// written. depends on nothing
module gpr_stack_mem #(
  parameter int NODES = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data
);

  logic [IDX_W-1:0] mem [NODES];
  logic [IDX_W-1:0] rd_data_r;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/graph_path_reachability_core.sv @@
// graph_path_reachability_core: directed graph kept as an adjacency matrix,
// edge add/remove and depth-first path queries. An edit reads the matrix row
// and writes it back with the edge bit changed. A query walks one matrix row
// read, one stack read and one stack write per node; a hit ends the walk
// early. One item at a time; a result may wait while the next item is taken.
// Synchronous reset clears control and matrix.
module graph_path_reachability_core #(
  parameter int NODE_COUNT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gpr_pkg::MODE_W-1:0] in_mode,
  input  logic [gpr_pkg::NODE_W-1:0] in_from_node,
  input  logic [gpr_pkg::NODE_W-1:0] in_to_node,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_reachable
);

  import gpr_pkg::*;

  // only node indices that fit the item fields can ever hold an edge
  localparam int NODES = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEP_W = IDX_W + 1;
  localparam logic [NODE_W:0] NODE_LIM = (NODE_W + 1)'(NODES);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] src_r, src_nxt;
  logic [IDX_W-1:0] dst_r, dst_nxt;
  logic [DEP_W-1:0] depth_r, depth_nxt;
  logic [NODES-1:0] visited_r, visited_nxt;
  logic [NODES-1:0] fresh_r, fresh_nxt;
  logic             found_r, found_nxt;
  logic             add_r, add_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_reachable_r, out_reachable_nxt;

  logic             row_rd_en;
  logic [IDX_W-1:0] row_rd_addr;
  logic [NODES-1:0] row_rd_data;
  logic             row_wr_en;
  logic [NODES-1:0] row_wr_data;
  logic             stk_rd_en;
  logic [IDX_W-1:0] stk_rd_addr;
  logic [IDX_W-1:0] stk_rd_data;
  logic             stk_wr_en;
  logic [IDX_W-1:0] stk_wr_data;

  logic             in_range;
  logic [NODES-1:0] dst_bit;
  logic [NODES-1:0] fresh_row;

  // lowest set bit of a node vector
  function automatic logic [IDX_W-1:0] lowest_set(input logic [NODES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  gpr_edge_mem #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_edge_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data),
    .wr_en   (row_wr_en),
    .wr_addr (src_r),
    .wr_data (row_wr_data)
  );

  gpr_stack_mem #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_stack_mem (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (stk_wr_en),
    .wr_addr (depth_r[IDX_W-1:0]),
    .wr_data (stk_wr_data)
  );

  // item decode helpers
  assign in_range  = ({1'b0, in_from_node} < NODE_LIM) && ({1'b0, in_to_node} < NODE_LIM);
  assign dst_bit   = NODES'(1) << dst_r;
  assign fresh_row = row_rd_data & ~visited_r;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_reachable = out_reachable_r;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r           <= src_nxt;
    dst_r           <= dst_nxt;
    visited_r       <= visited_nxt;
    fresh_r         <= fresh_nxt;
    found_r         <= found_nxt;
    add_r           <= add_nxt;
    out_reachable_r <= out_reachable_nxt;
  end

  // sequencer: edits, search walk and result hand-off
  always_comb begin
    state_nxt         = state_r;
    src_nxt           = src_r;
    dst_nxt           = dst_r;
    depth_nxt         = depth_r;
    visited_nxt       = visited_r;
    fresh_nxt         = fresh_r;
    found_nxt         = found_r;
    add_nxt           = add_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_reachable_nxt = out_reachable_r;
    row_rd_en         = 1'b0;
    row_rd_addr       = in_from_node[IDX_W-1:0];
    row_wr_en         = 1'b0;
    row_wr_data       = add_r ? (row_rd_data | dst_bit) : (row_rd_data & ~dst_bit);
    stk_rd_en         = 1'b0;
    stk_rd_addr       = depth_r[IDX_W-1:0] - IDX_W'(1);
    stk_wr_en         = 1'b0;
    stk_wr_data       = lowest_set(fresh_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          src_nxt = in_from_node[IDX_W-1:0];
          dst_nxt = in_to_node[IDX_W-1:0];
          case (mode_t'(in_mode))
            MODE_ADD, MODE_REMOVE: begin
              add_nxt = (mode_t'(in_mode) == MODE_ADD);
              if (in_range) begin
                row_rd_en = 1'b1;
                state_nxt = S_EDIT;
              end
            end
            MODE_QUERY: begin
              if (!in_range) begin
                found_nxt = 1'b0;
                state_nxt = S_DONE;
              end else if (in_from_node == in_to_node) begin
                found_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                // source is expanded directly, it never enters the stack
                visited_nxt = NODES'(1) << in_from_node[IDX_W-1:0];
                depth_nxt   = '0;
                row_rd_en   = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // row back from memory, write it with the edge bit changed
      S_EDIT: begin
        row_wr_en = 1'b1;
        state_nxt = S_IDLE;
      end

      // row of the current node: end on a hit, else mark unvisited successors
      S_SCAN: begin
        if ((fresh_row & dst_bit) != '0) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          visited_nxt = visited_r | fresh_row;
          fresh_nxt   = fresh_row;
          state_nxt   = S_PUSH;
        end
      end

      // push successors lowest first, then pop the next node or end when the stack is empty
      S_PUSH: begin
        if (fresh_r != '0) begin
          stk_wr_en = 1'b1;
          depth_nxt = depth_r + DEP_W'(1);
          fresh_nxt = fresh_r & (fresh_r - NODES'(1));
        end else if (depth_r == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          stk_rd_en = 1'b1;
          depth_nxt = depth_r - DEP_W'(1);
          state_nxt = S_POP;
        end
      end

      // popped node back from the stack, fetch its row
      S_POP: begin
        row_rd_en   = 1'b1;
        row_rd_addr = stk_rd_data;
        src_nxt     = stk_rd_data;
        state_nxt   = S_SCAN;
      end

      // hand the answer to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_reachable_nxt = found_r;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // stack never holds more than every node but the source
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r < DEP_W'(NODES))
    else $error("search stack depth out of range");

  // every successor being pushed is already marked visited
  a_push_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> ((fresh_r & ~visited_r) == '0))
    else $error("pushed node not marked visited");

  // a new result only ever comes from the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  // the destination is never marked while the search is still walking
  a_dst_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH || state_r == S_POP) |-> ((visited_r & dst_bit) == '0))
    else $error("destination visited without a hit");

endmodule
